// ===== rtl/rmp_pkg.sv =====
// shared types, register indexes and channel-wise max for the rgb max pooling block
package rmp_pkg;

   localparam int PIX_W  = 24;
   localparam int CHAN_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int IMG_DIM_W  = 12;
   localparam int STRIDE_W   = 5;
   localparam int ROW_W      = 11;
   localparam logic [IMG_DIM_W-1:0] HEIGHT_LIMIT = 12'd2048;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE       = 2'd2;

   typedef struct packed {
      logic [IMG_DIM_W-1:0] image_width;
      logic [IMG_DIM_W-1:0] image_height;
      logic [STRIDE_W-1:0]  stride;
   } cfg_type;

   // what the scan stage hands to the merge stage for one pixel
   typedef struct packed {
      logic [PIX_W-1:0] row_max;
      logic             col_end;
      logic             row_end;
      logic             use_store;
      logic             last_col;
      logic             last_row;
   } scan_item_type;

   function automatic logic [PIX_W-1:0] pix_max(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] r;
      r = '0;
      for (int c = 0; c < PIX_W / CHAN_W; c++) begin
         r[c*CHAN_W +: CHAN_W] = (a[c*CHAN_W +: CHAN_W] > b[c*CHAN_W +: CHAN_W]) ?
                                 a[c*CHAN_W +: CHAN_W] : b[c*CHAN_W +: CHAN_W];
      end
      return r;
   endfunction

endpackage

// ===== rtl/rgb_max_pool_stream.sv =====
// top level of the streaming rgb max pooling block
//
//   group  dir  width  contents
//   req_   in   24     pixel beat: tdata = red, green, blue
//   rsp_   out  24+2   pooled beat: tdata = red, green, blue; tlast = row end;
//                      tuser = frame end
//   csr_   in   2+12   register write: index, data
//
// one pixel per cycle unless stalled by rsp_; a pooled pixel leaves after its
// window's bottom right pixel (line store read, then merge and output register).
// the line store has one read and one write port; a write and a read of the same
// column on one edge are resolved by a bypass register.
// synchronous reset; the line store is not cleared, its data is used only once written.
// rsp_ backpressure stalls req_ only when a pooled pixel is waiting behind a full
// output register.
module rgb_max_pool_stream
   import rmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_STRIDE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // in_red, in_green, in_blue
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // out_red, out_green, out_blue
   output logic                  rsp_tlast,   // row_end
   output logic                  rsp_tuser,   // frame_end
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   cfg_type          cfg_ff;
   logic             restart;
   logic             accept, advance;
   scan_item_type    item;
   logic [COL_W-1:0] rd_addr, wr_addr;
   logic [PIX_W-1:0] rd_data, wr_data, pixel;
   logic             wr_en;

   // tdata carries red in the low byte, the scan works on red in the high byte
   assign pixel = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 12'd640;
         cfg_ff.image_height <= 12'd480;
         cfg_ff.stride       <= 5'd2;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            CSR_STRIDE:       cfg_ff.stride       <= csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_STRIDE: restart = csr_wr_en;
         default: restart = 1'b0;
      endcase
   end

   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   rmp_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_STRIDE (MAX_STRIDE)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .restart (restart),
      .accept  (accept),
      .pixel   (pixel),
      .item    (item),
      .rd_addr (rd_addr)
   );

   rmp_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   logic [PIX_W-1:0] out_pix;

   rmp_merge #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .advance   (advance),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (out_pix),
      .rsp_last  (rsp_tlast),
      .rsp_user  (rsp_tuser)
   );

   assign rsp_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};

endmodule

// ===== rtl/rmp_line_store.sv =====
// line store of partial window maxima, one entry per output column
module rmp_line_store
   import rmp_pkg::*;
#(
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [PIX_W-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [PIX_W-1:0]         wr_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rmp_scan.sv =====
// raster position counters, window phases and running row maximum
module rmp_scan
   import rmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_STRIDE = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         restart,
   input  logic                         accept,
   input  logic [PIX_W-1:0]             pixel,
   output scan_item_type                item,
   output logic [$clog2(MAX_WIDTH)-1:0] rd_addr
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
   localparam int WW     = (WW_RAW > IMG_DIM_W) ? WW_RAW : IMG_DIM_W;
   localparam int PH_W   = $clog2(MAX_STRIDE);
   localparam int SW_RAW = $clog2(MAX_STRIDE + 1);
   localparam int SW     = (SW_RAW > STRIDE_W) ? SW_RAW : STRIDE_W;
   localparam logic [WW-1:0] WIDTH_LIMIT  = WW'(MAX_WIDTH);
   localparam logic [SW-1:0] STRIDE_LIMIT = SW'(MAX_STRIDE);

   logic [COL_W-1:0] pixel_column_ff, pixel_column_in;
   logic [ROW_W-1:0] pixel_row_ff, pixel_row_in;
   logic [PH_W-1:0]  column_phase_ff, column_phase_in;
   logic [PH_W-1:0]  row_phase_ff, row_phase_in;
   logic [COL_W-1:0] out_column_ff, out_column_in;
   logic [PIX_W-1:0] row_max_ff, row_max_in;

   logic [WW-1:0]        width_raw, width_eff;
   logic [IMG_DIM_W-1:0] height_eff;
   logic [SW-1:0]        stride_raw, stride_eff;
   logic                 last_col, last_row, col_end, row_end;

   // zero reads as one, oversize saturates
   always_comb begin
      width_raw  = WW'(cfg.image_width);
      stride_raw = SW'(cfg.stride);
      if (width_raw == '0) begin
         width_eff = WW'(1);
      end else if (width_raw > WIDTH_LIMIT) begin
         width_eff = WIDTH_LIMIT;
      end else begin
         width_eff = width_raw;
      end
      if (cfg.image_height == '0) begin
         height_eff = IMG_DIM_W'(1);
      end else if (cfg.image_height > HEIGHT_LIMIT) begin
         height_eff = HEIGHT_LIMIT;
      end else begin
         height_eff = cfg.image_height;
      end
      if (stride_raw == '0) begin
         stride_eff = SW'(1);
      end else if (stride_raw > STRIDE_LIMIT) begin
         stride_eff = STRIDE_LIMIT;
      end else begin
         stride_eff = stride_raw;
      end
   end

   always_comb begin
      last_col = (WW'(pixel_column_ff) + WW'(1)) >= width_eff;
      last_row = (IMG_DIM_W'(pixel_row_ff) + IMG_DIM_W'(1)) >= height_eff;
      col_end  = last_col || ((SW'(column_phase_ff) + SW'(1)) >= stride_eff);
      row_end  = last_row || ((SW'(row_phase_ff) + SW'(1)) >= stride_eff);
      row_max_in = (column_phase_ff == '0) ? pixel : pix_max(row_max_ff, pixel);

      item.row_max   = row_max_in;
      item.col_end   = col_end;
      item.row_end   = row_end;
      item.use_store = (row_phase_ff != '0);
      item.last_col  = last_col;
      item.last_row  = last_row;

      pixel_column_in = pixel_column_ff;
      pixel_row_in    = pixel_row_ff;
      column_phase_in = column_phase_ff;
      row_phase_in    = row_phase_ff;
      out_column_in   = out_column_ff;
      if (col_end) begin
         out_column_in = out_column_ff + COL_W'(1);
      end
      if (last_col) begin
         pixel_column_in = '0;
         column_phase_in = '0;
         out_column_in   = '0;
         if (last_row) begin
            pixel_row_in = '0;
            row_phase_in = '0;
         end else begin
            pixel_row_in = pixel_row_ff + ROW_W'(1);
            row_phase_in = row_end ? '0 : row_phase_ff + PH_W'(1);
         end
      end else begin
         pixel_column_in = pixel_column_ff + COL_W'(1);
         column_phase_in = col_end ? '0 : column_phase_ff + PH_W'(1);
      end
   end

   assign rd_addr = out_column_ff;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pixel_column_ff <= '0;
         pixel_row_ff    <= '0;
         column_phase_ff <= '0;
         row_phase_ff    <= '0;
         out_column_ff   <= '0;
         row_max_ff      <= '0;
      end else if (accept) begin
         pixel_column_ff <= pixel_column_in;
         pixel_row_ff    <= pixel_row_in;
         column_phase_ff <= column_phase_in;
         row_phase_ff    <= row_phase_in;
         out_column_ff   <= out_column_in;
         row_max_ff      <= row_max_in;
      end
   end

endmodule

// ===== rtl/rmp_merge.sv =====
// merge stage: folds line store data into the window max, writes back or emits
module rmp_merge
   import rmp_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  scan_item_type                item,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [PIX_W-1:0]             rd_data,
   output logic                         advance,
   output logic                         wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   output logic [PIX_W-1:0]             wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [PIX_W-1:0]             rsp_data,
   output logic                         rsp_last,
   output logic                         rsp_user
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             s1_valid_ff;
   scan_item_type    s1_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic             byp_ff;
   logic [PIX_W-1:0] byp_data_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_last_ff, rsp_user_ff;

   logic [PIX_W-1:0] store_val, win_max;
   logic             emit;

   always_comb begin
      // a read issued on the edge that wrote the same column sees stale data
      store_val = byp_ff ? byp_data_ff : rd_data;
      win_max   = s1_ff.use_store ? pix_max(store_val, s1_ff.row_max) : s1_ff.row_max;
      emit      = s1_valid_ff && s1_ff.col_end && s1_ff.row_end;
      wr_en     = s1_valid_ff && s1_ff.col_end && !s1_ff.row_end;
      advance   = !emit || !rsp_valid_ff || rsp_ready;
   end

   assign wr_addr   = s1_addr_ff;
   assign wr_data   = win_max;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_user  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         byp_ff      <= accept && wr_en && (s1_addr_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= item;
         s1_addr_ff  <= rd_addr;
         byp_data_ff <= win_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && advance) begin
         rsp_data_ff <= win_max;
         rsp_last_ff <= s1_ff.last_col;
         rsp_user_ff <= s1_ff.last_col && s1_ff.last_row;
      end
   end

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("merge stage dropped an item while stalled");

   a_bypass_follows_write: assert property (@(posedge clock) disable iff (reset)
      $rose(byp_ff) |-> $past(wr_en))
      else $error("bypass armed without a line store write");

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_last_ff)
      else $error("frame end beat without row end");

   a_no_write_on_emit: assert property (@(posedge clock) disable iff (reset)
      emit |-> !wr_en)
      else $error("window both emitted and written back");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the streaming rgb max pooling block
`timescale 1ns / 1ps

module testbench;
   import rmp_pkg::*;

   localparam int WIDTH_CAP   = 2048;
   localparam int HEIGHT_CAP  = 2048;
   localparam int STRIDE_CAP  = 16;
   localparam int RANDOM_PIXELS = 1950;
   localparam int CAP_PIXELS  = 160;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] rgb;
      logic             row_end;
      logic             frame_end;
   } pooled_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;   // in_red, in_green, in_blue
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;        // out_red, out_green, out_blue
   logic                  rsp_tlast;        // row_end
   logic                  rsp_tuser;        // frame_end
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_max_pool_stream uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and expectations
   logic [PIX_W-1:0] pixel_backlog [$];
   pooled_type       pending_pooled [$];
   int pixels_queued = 0;
   int pixels_taken = 0;
   int pooled_seen = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int pix_gap_pct = 0;
   int rsp_stall_pct = 0;
   logic pix_beat_taken = 1'b0;
   logic long_hold_armed = 1'b0;
   int long_hold_count = 0;
   pooled_type want;

   // predictor state
   logic [IMG_DIM_W-1:0] cfg_width;
   logic [IMG_DIM_W-1:0] cfg_height;
   logic [STRIDE_W-1:0]  cfg_stride;
   int scan_col, scan_row, col_phase, row_phase, pool_col;
   logic [PIX_W-1:0] window_max;
   logic [PIX_W-1:0] band_max [0:WIDTH_CAP-1];

   function automatic int limit_dim(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] channel_max3(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] r;
      for (int c = 0; c < 3; c++)
         r[c*8 +: 8] = (a[c*8 +: 8] > b[c*8 +: 8]) ? a[c*8 +: 8] : b[c*8 +: 8];
      return r;
   endfunction

   task automatic restart_scan();
      scan_col = 0;
      scan_row = 0;
      col_phase = 0;
      row_phase = 0;
      pool_col = 0;
      window_max = '0;
   endtask

   task automatic pool_pixel(input logic [PIX_W-1:0] px);
      int w, h, s;
      bit last_col, last_row, col_end, row_done;
      logic [PIX_W-1:0] v;
      pooled_type e;
      w = limit_dim(int'(cfg_width), WIDTH_CAP);
      h = limit_dim(int'(cfg_height), HEIGHT_CAP);
      s = limit_dim(int'(cfg_stride), STRIDE_CAP);
      last_col = (scan_col + 1 >= w);
      last_row = (scan_row + 1 >= h);
      col_end  = last_col || (col_phase + 1 >= s);
      row_done = last_row || (row_phase + 1 >= s);
      window_max = (col_phase == 0) ? px : channel_max3(window_max, px);
      if (col_end) begin
         v = window_max;
         if (row_phase != 0)
            v = channel_max3(band_max[pool_col], v);
         if (row_done) begin
            e.rgb = v;
            e.row_end = last_col;
            e.frame_end = last_col && last_row;
            pending_pooled.push_back(e);
         end else begin
            band_max[pool_col] = v;
         end
         pool_col++;
      end
      if (last_col) begin
         scan_col = 0;
         col_phase = 0;
         pool_col = 0;
         if (last_row) begin
            scan_row = 0;
            row_phase = 0;
         end else begin
            scan_row++;
            row_phase = row_done ? 0 : row_phase + 1;
         end
      end else begin
         scan_col++;
         col_phase = col_end ? 0 : col_phase + 1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || pix_beat_taken) begin
         if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= pix_gap_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pixel_backlog.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result sink, with one long hold-off when armed
   always @(negedge clock) begin
      if (long_hold_armed && long_hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         long_hold_count <= long_hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // beat monitor: predict on accepted pixels, check accepted pooled beats
   always @(posedge clock) begin
      if (reset) begin
         pix_beat_taken <= 1'b0;
      end else begin
         pix_beat_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            pool_pixel(req_tdata);
            pixels_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pooled.size() == 0) begin
               report_mismatch($sformatf("pooled beat %h with none expected", rsp_tdata));
            end else begin
               want = pending_pooled.pop_front();
               for (int c = 0; c < 3; c++)
                  if (rsp_tdata[c*8 +: 8] !== want.rgb[c*8 +: 8])
                     report_mismatch($sformatf("beat %0d channel %0d got %h want %h",
                        pooled_seen, c, rsp_tdata[c*8 +: 8], want.rgb[c*8 +: 8]));
               if (rsp_tlast !== want.row_end)
                  report_mismatch($sformatf("beat %0d row end got %b want %b",
                     pooled_seen, rsp_tlast, want.row_end));
               if (rsp_tuser !== want.frame_end)
                  report_mismatch($sformatf("beat %0d frame end got %b want %b",
                     pooled_seen, rsp_tuser, want.frame_end));
            end
            pooled_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: begin
            cfg_width = data;
            restart_scan();
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = data;
            restart_scan();
         end
         CSR_STRIDE: begin
            cfg_stride = data[STRIDE_W-1:0];
            restart_scan();
         end
         default: ;
      endcase
   endtask

   task automatic set_idling(input int mode);
      @(posedge clock);
      case (mode)
         0: begin
            pix_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            pix_gap_pct = 46;
            rsp_stall_pct = 0;
         end
         2: begin
            pix_gap_pct = 0;
            rsp_stall_pct = 46;
         end
         default: begin
            pix_gap_pct = 11;
            rsp_stall_pct = 11;
         end
      endcase
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] px);
      pixel_backlog.push_back(px);
      pixels_queued++;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] px;
      case ($urandom_range(0, 7))
         0: px = '0;
         1: px = '1;
         2: begin
            for (int c = 0; c < 3; c++)
               case ($urandom_range(0, 3))
                  0: px[c*8 +: 8] = 8'h00;
                  1: px[c*8 +: 8] = 8'hff;
                  2: px[c*8 +: 8] = 8'h80;
                  default: px[c*8 +: 8] = 8'h7f;
               endcase
         end
         default: px = PIX_W'($urandom);
      endcase
      return px;
   endfunction

   // wait until every pixel is taken and every pooled beat has arrived,
   // then give the pipeline time for pixels that make no beat
   task automatic settle();
      while (pixels_taken != pixels_queued || pending_pooled.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h,
                               input logic [CSR_DATA_W-1:0] s);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_STRIDE, s);
   endtask

   initial begin
      int setting;
      int w, h, frames, extra, count;
      logic [CSR_DATA_W-1:0] w_reg, h_reg, s_reg;

      cfg_width = 12'd640;
      cfg_height = 12'd480;
      cfg_stride = 5'd2;
      restart_scan();
      for (int i = 0; i < WIDTH_CAP; i++)
         band_max[i] = '0;
      setting = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // a few pixels under the reset geometry make no beat yet
      set_idling(3);
      push_pixel('0);
      push_pixel('1);
      push_pixel(24'h5a5a5a);
      settle();

      // zero registers act as one: every pixel is its own image
      set_geometry('0, '0, '0);
      push_pixel('0);
      push_pixel('1);
      push_pixel(24'haa55aa);
      push_pixel(24'h55aa55);
      settle();

      // a write to the unused index must not restart the image
      set_geometry(12'd3, 12'd2, 12'd2);
      push_pixel(24'h10f020);
      push_pixel(24'hf01030);
      settle();
      write_reg(CSR_UNUSED_IDX, '1);
      push_pixel(24'h2020f0);
      push_pixel(24'h000001);
      push_pixel(24'h808080);
      push_pixel(24'h7f7f7f);
      settle();

      // a write to a used register, here the stride, restarts the image mid-frame
      set_geometry(12'd2, 12'd2, 12'd2);
      push_pixel(24'h0000ff);
      push_pixel(24'h00ff00);
      push_pixel(24'hff0000);
      settle();
      write_reg(CSR_STRIDE, 12'd2);
      push_pixel(24'h010203);
      push_pixel(24'h030201);
      push_pixel(24'h020301);
      push_pixel(24'h000000);
      settle();

      // width and stride past their caps, the start of one long row
      set_idling(1);
      set_geometry('1, 12'd1, '1);
      repeat (CAP_PIXELS) push_pixel(random_pixel());
      settle();

      // height past its cap, one pixel per row
      set_idling(2);
      set_geometry(12'd1, '1, 12'd16);
      repeat (CAP_PIXELS) push_pixel(random_pixel());
      settle();

      // stride one makes a beat per pixel; hold the sink off so the block backs up
      set_idling(0);
      set_geometry(12'd8, 12'd8, 12'd1);
      long_hold_armed = 1'b1;
      repeat (64) push_pixel(random_pixel());
      settle();

      while (pixels_queued < RANDOM_PIXELS) begin
         setting++;
         set_idling(setting % 4);
         w_reg = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 24));
         h_reg = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 10));
         case ($urandom_range(0, 9))
            0: s_reg = 12'd0;
            1: s_reg = 12'($urandom_range(17, 31));
            2: s_reg = 12'd16;
            default: s_reg = 12'($urandom_range(1, 6));
         endcase
         if ($urandom_range(0, 4) == 0)
            write_reg(CSR_UNUSED_IDX, 12'($urandom));
         set_geometry(w_reg, h_reg, s_reg);
         w = limit_dim(int'(w_reg), WIDTH_CAP);
         h = limit_dim(int'(h_reg), HEIGHT_CAP);
         frames = $urandom_range(1, 3);
         // sometimes leave a frame unfinished so the next write cuts it off
         extra = ($urandom_range(0, 2) == 0 && w * h > 1) ? $urandom_range(1, w * h - 1) : 0;
         count = frames * w * h + extra;
         repeat (count) push_pixel(random_pixel());
         settle();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rmp_pkg.sv
rtl/rmp_line_store.sv
rtl/rmp_scan.sv
rtl/rmp_merge.sv
rtl/rgb_max_pool_stream.sv
test/testbench.sv
